// File: hdl/sorted_keyed_accumulator_table_top_defines.svh
// assertion macros used by the checker file
`ifndef SORTED_KEYED_ACCUMULATOR_TABLE_TOP_DEFINES_SVH
`define SORTED_KEYED_ACCUMULATOR_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define SKAT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("skat property violated");

// next-cycle implication
`define SKAT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("skat property violated");

`endif

// File: hdl/skat_pkg.sv
package skat_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int KEY_BITS    = 30;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);

	localparam int NUMBER_W = 30;
	localparam int PRICE_W  = 10;
	localparam int RANK_W   = 5;
	localparam int STATUS_W = 2;
	localparam int CALLS_W  = 32;
	localparam int TOTAL_W  = 32;
	localparam int USED_W   = 6;

	localparam int IN_FIELDS_W  = NUMBER_W + PRICE_W + RANK_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = NUMBER_W + CALLS_W + TOTAL_W + USED_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic CMD_LOG  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_UPDATED  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NO_RANK  = 2'd3;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [CALLS_W-1:0]  calls;
		logic [TOTAL_W-1:0]  total;
	} entry_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic                cmp_en;
		logic                do_update;
		logic                do_insert;
		logic [KEY_BITS-1:0] key;
		logic [PRICE_W-1:0]  price;
	} cell_ctrl_t;

	function automatic logic [CALLS_W-1:0] sat_inc(input logic [CALLS_W-1:0] a);
		return (&a) ? a : a + CALLS_W'(1);
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_add_price(input logic [TOTAL_W-1:0] a,
			input logic [PRICE_W-1:0] p);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + (TOTAL_W + 1)'(p);
		return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
	endfunction

endpackage

// File: hdl/skat_cell.sv
module skat_cell import skat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       occupied,   // this slot lies below the fill count
	input  cell_ctrl_t ctrl,
	input  entry_t     prev_entry, // left neighbor, shifted in on insert
	input  logic       prev_at,    // left neighbor is at or past the insert point
	output entry_t     entry,
	output logic       eq,
	output logic       at
);

	entry_t entry_q;
	logic   eq_q;
	logic   at_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_q <= 1'b0;
			at_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			eq_q <= occupied && (entry_q.key == ctrl.key);
			at_q <= !occupied || (entry_q.key > ctrl.key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.do_update && eq_q) begin
			entry_q.calls <= sat_inc(entry_q.calls);
			entry_q.total <= sat_add_price(entry_q.total, ctrl.price);
		end else if (ctrl.do_insert && at_q) begin
			if (prev_at) begin
				entry_q <= prev_entry;
			end else begin
				entry_q.key   <= ctrl.key;
				entry_q.calls <= CALLS_W'(1);
				entry_q.total <= TOTAL_W'(ctrl.price);
			end
		end
	end

	assign entry = entry_q;
	assign eq    = eq_q;
	assign at    = at_q;

endmodule

// File: hdl/sorted_keyed_accumulator_table_top.sv
// sorted keyed accumulator table: up to 32 entries kept in ascending phone
// number order, each with a saturating call count and cost total. a log word
// (tuser 0) bumps the matching entry or inserts a new one at its sorted place;
// a read word (tuser 1) returns the entry at a rank. every item passes a
// compare state, where all cells compare the key in parallel, and then an
// update state, where they update or shift right by one toward the neighbor;
// the update state waits while an untaken result holds the output register.
// the next word is taken in the update state of the current one once its result
// can leave, and the result register lets a finished result wait while the next
// item is compared. the entries need no clearing: the fill count is reset.
module sorted_keyed_accumulator_table_top import skat_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // phone_number, call_price, read_rank, zero pad
	input  logic                  s_tuser,  // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // entry_number, entry_calls, entry_total,
	                                        // entries_used, zero pad
	output logic [STATUS_W-1:0]   m_tuser   // status
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]           state_q;
	logic [1:0]           state_d;
	logic [OCC_W-1:0]     occ_q;

	// captured input word
	logic                 cmd_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [PRICE_W-1:0]   price_q;
	logic [RANK_W-1:0]    rank_q;

	// output register
	logic                   m_valid_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [NUMBER_W-1:0]    res_number_q;
	logic [CALLS_W-1:0]     res_calls_q;
	logic [TOTAL_W-1:0]     res_total_q;
	logic [USED_W-1:0]      res_used_q;

	logic in_fire;
	logic out_free;
	logic upd_go;
	logic match;
	logic full;
	logic do_insert;
	logic rank_ok;

	cell_ctrl_t ctrl;
	entry_t     cell_entry [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cell_eq;
	logic [TABLE_DEPTH-1:0] cell_at;
	entry_t     hit_entry;
	entry_t     rank_entry;

	logic [STATUS_W-1:0] nx_status;
	logic [NUMBER_W-1:0] nx_number;
	logic [CALLS_W-1:0]  nx_calls;
	logic [TOTAL_W-1:0]  nx_total;

	// handshake: new word in idle, or in the update cycle when the result can leave
	assign out_free = !m_valid_q || m_tready;
	assign upd_go   = (state_q == ST_UPD) && out_free;
	assign s_tready = (state_q == ST_IDLE) || upd_go;
	assign in_fire  = s_tvalid && s_tready;

	assign match     = |cell_eq;
	assign full      = (occ_q == OCC_W'(TABLE_DEPTH));
	assign do_insert = upd_go && (cmd_q == CMD_LOG) && !match && !full;

	assign ctrl.cmp_en    = (state_q == ST_CMP);
	assign ctrl.do_update = upd_go && (cmd_q == CMD_LOG) && match;
	assign ctrl.do_insert = do_insert;
	assign ctrl.key       = key_q;
	assign ctrl.price     = price_q;

	// row of cells, each shifting into its right neighbor on insert
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic   occupied;
		entry_t prev_entry;
		logic   prev_at;

		assign occupied = (32'(i) < 32'(occ_q));
		if (i == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_at    = 1'b0;
		end else begin : g_body
			assign prev_entry = cell_entry[i-1];
			assign prev_at    = cell_at[i-1];
		end

		skat_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.occupied   (occupied),
			.ctrl       (ctrl),
			.prev_entry (prev_entry),
			.prev_at    (prev_at),
			.entry      (cell_entry[i]),
			.eq         (cell_eq[i]),
			.at         (cell_at[i])
		);
	end

	// the matching cell is at most one, so an or over the row selects it
	always_comb begin
		hit_entry = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (cell_eq[i]) begin
				hit_entry = hit_entry | cell_entry[i];
			end
		end
	end

	assign rank_ok    = (32'(rank_q) < 32'(occ_q));
	assign rank_entry = cell_entry[IDX_W'(rank_q)];

	always_comb begin
		nx_status = STAT_UPDATED;
		nx_number = NUMBER_W'(key_q);
		nx_calls  = '0;
		nx_total  = '0;
		if (cmd_q == CMD_READ) begin
			if (rank_ok) begin
				nx_number = NUMBER_W'(rank_entry.key);
				nx_calls  = rank_entry.calls;
				nx_total  = rank_entry.total;
			end else begin
				nx_status = STAT_NO_RANK;
				nx_number = '0;
			end
		end else if (match) begin
			nx_calls = sat_inc(hit_entry.calls);
			nx_total = sat_add_price(hit_entry.total, price_q);
		end else if (full) begin
			nx_status = STAT_FULL;
		end else begin
			nx_status = STAT_INSERTED;
			nx_calls  = CALLS_W'(1);
			nx_total  = TOTAL_W'(price_q);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (upd_go) begin
					state_d = in_fire ? ST_CMP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			occ_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_insert) begin
				occ_q <= occ_q + OCC_W'(1);
			end
			if (upd_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= s_tuser;
			key_q   <= KEY_BITS'(s_tdata[NUMBER_W-1:0]);
			price_q <= s_tdata[NUMBER_W +: PRICE_W];
			rank_q  <= s_tdata[NUMBER_W + PRICE_W +: RANK_W];
		end
	end

	// result capture, entries_used counts the insert of this item
	always_ff @(posedge clk) begin
		if (upd_go) begin
			res_status_q <= nx_status;
			res_number_q <= nx_number;
			res_calls_q  <= nx_calls;
			res_total_q  <= nx_total;
			res_used_q   <= USED_W'(occ_q) + USED_W'(do_insert);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
		res_used_q, res_total_q, res_calls_q, res_number_q};

endmodule

// File: hdl/skat_checker.sv
`include "sorted_keyed_accumulator_table_top_defines.svh"

module skat_checker import skat_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [STATUS_W-1:0]   m_tuser
);

	localparam int CALLS_LO = NUMBER_W;
	localparam int TOTAL_LO = NUMBER_W + CALLS_W;
	localparam int USED_LO  = NUMBER_W + CALLS_W + TOTAL_W;

	logic [CALLS_W-1:0] o_calls;
	logic [TOTAL_W-1:0] o_total;
	logic [USED_W-1:0]  o_used;

	assign o_calls = m_tdata[CALLS_LO +: CALLS_W];
	assign o_total = m_tdata[TOTAL_LO +: TOTAL_W];
	assign o_used  = m_tdata[USED_LO +: USED_W];

	// a stalled result holds
	`SKAT_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a new entry starts with one call and the price of that call
	`SKAT_ASSERT_IMP(a_insert_fresh, clk, arst_n, m_tvalid && (m_tuser == STAT_INSERTED), (o_calls == CALLS_W'(1)) && (o_total < TOTAL_W'(1 << PRICE_W)) && (o_used != '0))

	// a drop only happens on a full table and reports no calls or total
	`SKAT_ASSERT_IMP(a_full_drop, clk, arst_n, m_tvalid && (m_tuser == STAT_FULL), (o_used == USED_W'(TABLE_DEPTH)) && (o_calls == '0) && (o_total == '0))

	// an empty rank reports zeros and the table never exceeds its depth
	`SKAT_ASSERT_IMP(a_no_rank, clk, arst_n, m_tvalid && (m_tuser == STAT_NO_RANK), (m_tdata[USED_LO-1:0] == '0) && (o_used <= USED_W'(TABLE_DEPTH)))

	// after a word is taken the compare cycle takes none
	`SKAT_ASSERT_NXT(a_in_spacing, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind sorted_keyed_accumulator_table_top skat_checker u_skat_checker (.*);

// File: test/tb_sorted_keyed_accumulator_table_top.sv
module tb_sorted_keyed_accumulator_table_top;
	import skat_pkg::*;

	// one call record or rank query as it goes onto the slave side
	typedef struct {
		logic                cmd;
		logic [NUMBER_W-1:0] number;
		logic [PRICE_W-1:0]  price;
		logic [RANK_W-1:0]   rank;
		bit                  drain;  // hold this word until every result is back
	} call_word_t;

	// one result word as it should leave the master side
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [NUMBER_W-1:0] number;
		logic [CALLS_W-1:0]  calls;
		logic [TOTAL_W-1:0]  total;
		logic [USED_W-1:0]   used;
	} tally_t;

	localparam int POOL_SIZE    = 40;
	localparam int RANDOM_WORDS = 750;
	localparam int MAX_REPORTS  = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	sorted_keyed_accumulator_table_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow of the phone book, kept sorted by ascending number
	logic [NUMBER_W-1:0] book_key   [TABLE_DEPTH];
	logic [CALLS_W-1:0]  book_calls [TABLE_DEPTH];
	logic [TOTAL_W-1:0]  book_total [TABLE_DEPTH];
	int                  book_used = 0;

	call_word_t call_q[$];       // words still to be sent
	tally_t     tally_q[$];      // results owed by the block, oldest first
	call_word_t word_on_bus;

	int send_hold = 0;
	int recv_hold = 0;
	int cycles_seen = 0;
	int mismatches = 0;
	int words_taken = 0;
	int logs_taken = 0;
	int reads_taken = 0;
	int seen_updated = 0;
	int seen_inserted = 0;
	int seen_full = 0;
	int seen_no_rank = 0;

	logic [NUMBER_W-1:0] key_pool [POOL_SIZE];

	initial begin
		forever #2 clk = ~clk;
	end

	// reset released away from the active edge
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// generous ceiling, far above the slowest legal run
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic call_word_t make_word(logic cmd, logic [NUMBER_W-1:0] number,
			logic [PRICE_W-1:0] price, logic [RANK_W-1:0] rank);
		call_word_t w;
		w.cmd    = cmd;
		w.number = number;
		w.price  = price;
		w.rank   = rank;
		w.drain  = 1'b0;
		return w;
	endfunction

	// applies one accepted word to the shadow book and returns what the block owes
	function automatic tally_t tally_word(call_word_t w);
		tally_t              r;
		int                  slot;
		int                  hit;
		logic [TOTAL_W:0]    sum;
		slot = book_used;
		hit  = -1;
		if (w.cmd == CMD_READ) begin
			if (w.rank >= book_used)
				r = '{STAT_NO_RANK, '0, '0, '0, '0};
			else
				r = '{STAT_UPDATED, book_key[w.rank], book_calls[w.rank],
					book_total[w.rank], '0};
		end else begin
			for (int i = 0; i < book_used; i++) begin
				if (hit < 0 && book_key[i] == w.number)
					hit = i;
				if (book_key[i] > w.number && slot == book_used)
					slot = i;
			end
			if (hit >= 0) begin
				// both counters stick at all ones
				if (book_calls[hit] != '1)
					book_calls[hit] = book_calls[hit] + 1'b1;
				sum = {1'b0, book_total[hit]} + (TOTAL_W + 1)'(w.price);
				book_total[hit] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
				r = '{STAT_UPDATED, w.number, book_calls[hit], book_total[hit], '0};
			end else if (book_used >= TABLE_DEPTH) begin
				r = '{STAT_FULL, w.number, '0, '0, '0};
			end else begin
				// open a hole at the sorted place
				for (int i = book_used; i > slot; i--) begin
					book_key[i]   = book_key[i-1];
					book_calls[i] = book_calls[i-1];
					book_total[i] = book_total[i-1];
				end
				book_key[slot]   = w.number;
				book_calls[slot] = CALLS_W'(1);
				book_total[slot] = TOTAL_W'(w.price);
				book_used++;
				r = '{STAT_INSERTED, w.number, CALLS_W'(1), TOTAL_W'(w.price), '0};
			end
		end
		r.used = USED_W'(book_used);
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [CALLS_W-1:0] want,
			logic [CALLS_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	// sender: one word in flight, gaps drawn after each accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tally_q.push_back(tally_word(word_on_bus));
				words_taken++;
				if (word_on_bus.cmd == CMD_READ)
					reads_taken++;
				else
					logs_taken++;
				// every fourth hundred words go back to back
				send_hold = ((words_taken / 100) % 4 == 1) ? 0 : pause_len();
			end
			if (s_tvalid && !s_tready) begin
				// word still waiting for the block, hold it
			end else if (send_hold > 0) begin
				send_hold--;
				s_tvalid <= 1'b0;
			end else if (call_q.size() > 0 && (!call_q[0].drain || tally_q.size() == 0)) begin
				word_on_bus = call_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}},
					word_on_bus.rank, word_on_bus.price, word_on_bus.number};
				s_tuser  <= word_on_bus.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: checks each result word against the oldest one owed
	always @(posedge clk) begin
		tally_t want;
		if (arst_n) begin
			cycles_seen++;
			if (m_tvalid && m_tready) begin
				if (tally_q.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none expected, status %0d data %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = tally_q.pop_front();
					if (m_tuser !== want.status)
						note_mismatch("status", CALLS_W'(want.status), CALLS_W'(m_tuser));
					if (m_tdata[NUMBER_W-1:0] !== want.number)
						note_mismatch("entry_number", CALLS_W'(want.number),
							CALLS_W'(m_tdata[NUMBER_W-1:0]));
					if (m_tdata[NUMBER_W +: CALLS_W] !== want.calls)
						note_mismatch("entry_calls", want.calls, m_tdata[NUMBER_W +: CALLS_W]);
					if (m_tdata[NUMBER_W+CALLS_W +: TOTAL_W] !== want.total)
						note_mismatch("entry_total", want.total,
							m_tdata[NUMBER_W+CALLS_W +: TOTAL_W]);
					if (m_tdata[NUMBER_W+CALLS_W+TOTAL_W +: USED_W] !== want.used)
						note_mismatch("entries_used", CALLS_W'(want.used),
							CALLS_W'(m_tdata[NUMBER_W+CALLS_W+TOTAL_W +: USED_W]));
					case (want.status)
						STAT_UPDATED:  seen_updated++;
						STAT_INSERTED: seen_inserted++;
						STAT_FULL:     seen_full++;
						default:       seen_no_rank++;
					endcase
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				// quiet stretch every so often, otherwise stall at random
				if ((cycles_seen / 400) % 4 != 2 && $urandom_range(0, 3) == 0)
					recv_hold = pause_len();
			end
		end
	end

	initial begin
		call_word_t w;
		int         pick;
		// keys that the random part keeps coming back to; more than the table holds
		key_pool[0] = '0;
		key_pool[1] = NUMBER_W'(999999999);
		key_pool[2] = NUMBER_W'(500000000);
		key_pool[3] = NUMBER_W'(123456789);
		key_pool[4] = NUMBER_W'(536870912);
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = NUMBER_W'($urandom_range(0, 999999999));

		// empty table: reads find nothing
		call_q.push_back(make_word(CMD_READ, '0, '0, RANK_W'(0)));
		call_q.push_back(make_word(CMD_READ, '0, '0, RANK_W'(31)));
		// first insert, then at the front and at the back
		call_q.push_back(make_word(CMD_LOG, key_pool[2], '0, '0));
		call_q.push_back(make_word(CMD_LOG, key_pool[0], PRICE_W'(1023), '0));
		call_q.push_back(make_word(CMD_LOG, key_pool[1], PRICE_W'(1023), RANK_W'(31)));
		// repeat callers update in place
		call_q.push_back(make_word(CMD_LOG, key_pool[0], PRICE_W'(1), '0));
		call_q.push_back(make_word(CMD_LOG, key_pool[1], '0, '0));
		// insert in the middle shifts the tail
		call_q.push_back(make_word(CMD_LOG, key_pool[3], PRICE_W'(512), '0));
		call_q.push_back(make_word(CMD_LOG, key_pool[4], PRICE_W'(341), '0));
		call_q.push_back(make_word(CMD_LOG, key_pool[3], PRICE_W'(1023), '0));
		// reads at each occupied rank, then just past the end and the top rank
		for (int i = 0; i < 5; i++)
			call_q.push_back(make_word(CMD_READ, NUMBER_W'(999999999), PRICE_W'(1023),
				RANK_W'(i)));
		call_q.push_back(make_word(CMD_READ, '0, '0, RANK_W'(5)));
		call_q.push_back(make_word(CMD_READ, '0, '0, RANK_W'(31)));

		// random part: mostly pool callers so the table fills, updates and overflows
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			w = make_word(CMD_LOG, NUMBER_W'($urandom_range(0, 999999999)),
				PRICE_W'($urandom_range(0, 1023)), RANK_W'($urandom_range(0, 31)));
			if (pick < 55)
				w.number = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (pick >= 65)
				w.cmd = CMD_READ;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				w.price = '0;
			else if (pick == 1)
				w.price = '1;
			w.drain = (n == 0 || n == RANDOM_WORDS / 2);
			call_q.push_back(w);
		end

		while (call_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (tally_q.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d log and %0d read words, table ended with %0d entries",
			logs_taken, reads_taken, book_used);
		$display("results: %0d inserted, %0d updated or read, %0d dropped full, %0d empty rank",
			seen_inserted, seen_updated, seen_full, seen_no_rank);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
